[rtl/rle_pkg.sv]
// ----------------------------------------------------------------------------
// rle_pkg
// Shared constants, word types and control structures of the run-length
// byte encoder.
// ----------------------------------------------------------------------------
package rle_pkg;

   localparam int MAX_COUNT   = 127;
   localparam int OUT_LANES   = 8;
   localparam int BYTE_W      = 8;
   localparam int WORD_W      = 64;
   localparam int WORD_LANES  = WORD_W / BYTE_W;
   localparam int COUNT_W     = 4;
   localparam int LEN_W       = $clog2(MAX_COUNT + 1);
   localparam int STORE_DEPTH = MAX_COUNT - 1;
   localparam int ADDR_W      = $clog2(MAX_COUNT);

   localparam logic [BYTE_W-1:0] RUN_FLAG = 8'h80;
   localparam logic [BYTE_W-1:0] END_CODE = 8'h00;

   localparam logic CMD_DATA = 1'b0;
   localparam logic CMD_END  = 1'b1;

   typedef struct packed {
      logic              command;
      logic [BYTE_W-1:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0]  packed_bytes;
      logic [COUNT_W-1:0] byte_count;
      logic               final_group;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LIT_CTRL,
      ST_LIT_BODY,
      ST_LIT_TAIL,
      ST_RUN_CTRL,
      ST_RUN_BYTE,
      ST_END_CODE,
      ST_COMMIT
   } state_type;

   typedef enum logic [2:0] {
      SRC_LIT_CTRL,
      SRC_STORE,
      SRC_INPUT,
      SRC_RUN_CTRL,
      SRC_RUN_BYTE,
      SRC_END
   } src_type;

   typedef struct packed {
      logic lit;
      logic tail;
      logic run;
      logic end_code;
   } plan_type;

   typedef struct packed {
      logic    load;
      logic    push;
      logic    final_byte;
      src_type src;
      logic    rd_start;
      logic    rd_next;
      logic    commit;
   } dp_cmd_type;

   typedef struct packed {
      plan_type plan_new;
      plan_type plan;
      logic     body_last;
      logic     out_ready;
   } dp_status_type;

endpackage

[rtl/rle_ctrl.sv]
// ----------------------------------------------------------------------------
// rle_ctrl
// Sequencer of the encoder: takes a word, walks its code bytes (literal,
// run, end code) one per cycle when not stalled and commits the literal store.
// ----------------------------------------------------------------------------
module rle_ctrl
   import rle_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   function automatic state_type after_run(input plan_type p);
      return p.end_code ? ST_END_CODE : ST_COMMIT;
   endfunction

   function automatic state_type after_lit(input plan_type p);
      return p.run ? ST_RUN_CTRL : after_run(p);
   endfunction

   function automatic state_type first_state(input plan_type p);
      return p.lit ? ST_LIT_CTRL : after_lit(p);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = first_state(status.plan_new);
         end
         ST_LIT_CTRL: begin
            if (status.out_ready) state_in = ST_LIT_BODY;
         end
         ST_LIT_BODY: begin
            if (status.out_ready && status.body_last) begin
               state_in = status.plan.tail ? ST_LIT_TAIL : after_lit(status.plan);
            end
         end
         ST_LIT_TAIL: begin
            if (status.out_ready) state_in = after_lit(status.plan);
         end
         ST_RUN_CTRL: begin
            if (status.out_ready) state_in = ST_RUN_BYTE;
         end
         ST_RUN_BYTE: begin
            if (status.out_ready) state_in = after_run(status.plan);
         end
         ST_END_CODE: begin
            if (status.out_ready) state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall      = 1'b1;
      cmd            = '0;
      cmd.src        = SRC_END;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_LIT_CTRL: begin
            cmd.push     = status.out_ready;
            cmd.src      = SRC_LIT_CTRL;
            cmd.rd_start = status.out_ready;
         end
         ST_LIT_BODY: begin
            cmd.push       = status.out_ready;
            cmd.src        = SRC_STORE;
            cmd.rd_next    = status.out_ready && !status.body_last;
            cmd.final_byte = status.body_last && !status.plan.tail &&
                             !status.plan.run && !status.plan.end_code;
         end
         ST_LIT_TAIL: begin
            cmd.push       = status.out_ready;
            cmd.src        = SRC_INPUT;
            cmd.final_byte = !status.plan.run && !status.plan.end_code;
         end
         ST_RUN_CTRL: begin
            cmd.push = status.out_ready;
            cmd.src  = SRC_RUN_CTRL;
         end
         ST_RUN_BYTE: begin
            cmd.push       = status.out_ready;
            cmd.src        = SRC_RUN_BYTE;
            cmd.final_byte = !status.plan.end_code;
         end
         ST_END_CODE: begin
            cmd.push       = status.out_ready;
            cmd.src        = SRC_END;
            cmd.final_byte = 1'b1;
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
         end
         default: begin
            cmd.src = SRC_END;
         end
      endcase
   end

endmodule

[rtl/rle_dpath.sv]
// ----------------------------------------------------------------------------
// rle_dpath
// Encoder state, literal store, code byte selection and the output word
// packer with its output register.
// ----------------------------------------------------------------------------
module rle_dpath
   import rle_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  req_type       req_payload,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_type       rsp_payload
);

   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  rep_ff, rep_in;
   logic [BYTE_W-1:0] last_ff, last_in;

   plan_type          plan_ff, plan_in;
   logic [LEN_W-1:0]  mem_n_ff, mem_n_in;
   logic [BYTE_W-1:0] run_code_ff, run_code_in;
   logic [BYTE_W-1:0] run_byte_ff, run_byte_in;
   logic [BYTE_W-1:0] byte_ff;
   logic              wr_en_ff, wr_en_in;
   logic [ADDR_W-1:0] wr_addr_ff, wr_addr_in;

   logic [BYTE_W-1:0] store_mem [STORE_DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [ADDR_W-1:0] rd_addr;
   logic              rd_en;

   logic [WORD_W-1:0]  acc_ff, acc_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               final_ff, final_in;

   logic [LEN_W-1:0]  rep_inc;
   logic [LEN_W-1:0]  rep_two;
   logic [LEN_W:0]    len_inc;
   logic [BYTE_W-1:0] in_byte;
   logic [BYTE_W-1:0] push_byte;
   logic              out_ready;

   assign in_byte = req_payload.data_byte;
   assign rep_inc = rep_ff + LEN_W'(1);
   assign rep_two = rep_ff + LEN_W'(2);
   assign len_inc = {1'b0, len_ff} + (LEN_W + 1)'(1);

   // work out what this word emits and the encoder state it leaves
   always_comb begin
      plan_in     = '0;
      mem_n_in    = '0;
      run_code_in = RUN_FLAG;
      run_byte_in = last_ff;
      wr_en_in    = 1'b0;
      wr_addr_in  = '0;
      len_in      = len_ff;
      rep_in      = rep_ff;
      last_in     = last_ff;
      if (req_payload.command == CMD_END) begin
         plan_in.end_code = 1'b1;
         len_in           = '0;
         rep_in           = '0;
         if (rep_ff != '0) begin
            plan_in.run = 1'b1;
            run_code_in = RUN_FLAG | BYTE_W'(rep_inc);
         end else if (len_ff != '0) begin
            plan_in.lit = 1'b1;
            mem_n_in    = len_ff;
         end
      end else if (len_ff == '0) begin
         wr_en_in = 1'b1;
         len_in   = LEN_W'(1);
         last_in  = in_byte;
      end else if (in_byte == last_ff) begin
         if (rep_ff == '0 && len_ff >= LEN_W'(2)) begin
            plan_in.lit = 1'b1;
            mem_n_in    = len_ff - LEN_W'(1);
            wr_en_in    = 1'b1;
            len_in      = LEN_W'(1);
            rep_in      = LEN_W'(1);
         end else if (rep_inc >= LEN_W'(MAX_COUNT - 1)) begin
            plan_in.run = 1'b1;
            run_code_in = RUN_FLAG | BYTE_W'(rep_two);
            len_in      = '0;
            rep_in      = '0;
         end else begin
            rep_in = rep_inc;
         end
      end else begin
         if (rep_ff != '0) begin
            plan_in.run = 1'b1;
            run_code_in = RUN_FLAG | BYTE_W'(rep_inc);
            wr_en_in    = 1'b1;
            len_in      = LEN_W'(1);
            rep_in      = '0;
            last_in     = in_byte;
         end else if (len_inc >= (LEN_W + 1)'(MAX_COUNT)) begin
            plan_in.lit  = 1'b1;
            plan_in.tail = 1'b1;
            mem_n_in     = len_ff;
            len_in       = '0;
         end else begin
            wr_en_in   = 1'b1;
            wr_addr_in = len_ff[ADDR_W-1:0];
            len_in     = len_inc[LEN_W-1:0];
            last_in    = in_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= '0;
         rep_ff   <= '0;
         plan_ff  <= '0;
         wr_en_ff <= 1'b0;
      end else if (cmd.load) begin
         len_ff   <= len_in;
         rep_ff   <= rep_in;
         plan_ff  <= plan_in;
         wr_en_ff <= wr_en_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         last_ff     <= last_in;
         mem_n_ff    <= mem_n_in;
         run_code_ff <= run_code_in;
         run_byte_ff <= run_byte_in;
         byte_ff     <= in_byte;
         wr_addr_ff  <= wr_addr_in;
      end
   end

   // literal store: written at commit, read one entry per pushed byte
   assign rd_en   = cmd.rd_start || cmd.rd_next;
   assign rd_addr = cmd.rd_start ? '0 : idx_ff + ADDR_W'(1);
   assign idx_in  = rd_en ? rd_addr : idx_ff;

   always_ff @(posedge clock) begin
      if (cmd.commit && wr_en_ff) begin
         store_mem[wr_addr_ff] <= byte_ff;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   always_comb begin
      case (cmd.src)
         SRC_LIT_CTRL: push_byte = BYTE_W'(mem_n_ff) + BYTE_W'(plan_ff.tail);
         SRC_STORE:    push_byte = rd_data_ff;
         SRC_INPUT:    push_byte = byte_ff;
         SRC_RUN_CTRL: push_byte = run_code_ff;
         SRC_RUN_BYTE: push_byte = run_byte_ff;
         default:      push_byte = END_CODE;
      endcase
   end

   // packer: a push after a delivered word starts a fresh word
   assign out_ready = !(rsp_valid_ff && rsp_stall);

   always_comb begin
      logic [COUNT_W-1:0] base_cnt;
      base_cnt     = rsp_valid_ff ? '0 : cnt_ff;
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      final_in     = final_ff;
      if (cmd.push) begin
         for (int l = 0; l < WORD_LANES; l++) begin
            if (COUNT_W'(l) == base_cnt) begin
               acc_in[l*BYTE_W +: BYTE_W] = push_byte;
            end else if (COUNT_W'(l) > base_cnt) begin
               acc_in[l*BYTE_W +: BYTE_W] = '0;
            end
         end
         cnt_in       = base_cnt + COUNT_W'(1);
         final_in     = cmd.final_byte;
         rsp_valid_in = cmd.final_byte || (cnt_in == COUNT_W'(OUT_LANES));
      end else if (rsp_valid_ff && !rsp_stall) begin
         cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      final_ff <= final_in;
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_payload.packed_bytes = acc_ff;
   assign rsp_payload.byte_count   = cnt_ff;
   assign rsp_payload.final_group  = final_ff;

   assign status.plan_new  = plan_in;
   assign status.plan      = plan_ff;
   assign status.body_last = (LEN_W'(idx_ff) + LEN_W'(1)) == mem_n_ff;
   assign status.out_ready = out_ready;

   a_push_free: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> out_ready)
      else $error("byte pushed while the output word is held");

   a_word_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (cnt_ff != '0 && cnt_ff <= COUNT_W'(OUT_LANES)))
      else $error("output word with bad byte count");

   a_short_final: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && cnt_ff != COUNT_W'(OUT_LANES)) |-> final_ff)
      else $error("short output word that is not the last");

   a_run_single: assert property (@(posedge clock) disable iff (reset)
      (rep_ff != '0) |-> (len_ff == LEN_W'(1)))
      else $error("run pending with more than one stored byte");

   a_len_cap: assert property (@(posedge clock) disable iff (reset)
      len_ff < LEN_W'(MAX_COUNT))
      else $error("literal length reached the cap without flush");

endmodule

[rtl/rle_byte_encoder_core.sv]
// ----------------------------------------------------------------------------
// rle_byte_encoder_core
// Run-length byte encoder with 8-bit control codes, output packed eight
// bytes per word.
// ----------------------------------------------------------------------------
// Each accepted word is a data byte or an end-of-plane command. The code
// bytes a word releases (a full literal flush carries 127 bytes) go one at
// a time through the single byte lane into the output packer, fed from the
// one read port of the 126-entry literal store. A new word is not taken
// until the last one is committed, but it is taken while the last result
// word still waits in the output register; a held output stalls code byte
// generation. The store needs no clearing after reset.
module rle_byte_encoder_core
   import rle_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   dp_cmd_type    cmd;
   dp_status_type status;

   rle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rle_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the run-length byte encoder. Data bytes and
// end-of-plane commands go in through a bursty sender. Every accepted word
// runs through a local encoder model, which queues the packed code words it
// should produce. The result side stalls in changing patterns, and every
// result word is compared field by field with the oldest queued code word.
// ----------------------------------------------------------------------------
module tb_top
   import rle_pkg::*;
;

   localparam int LIMIT_CYCLES = 500000;
   localparam int DRAIN_CYCLES = 300;
   localparam int TARGET_WORDS = 470;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   req_type     source_words[$];
   rsp_type     coded_words[$];
   logic [7:0]  code_bytes[$];
   logic [7:0]  held_bytes[0:127];
   int unsigned held_len = 0;
   int unsigned run_extra = 0;
   logic [7:0]  last_pushed = 8'h00;

   int burst_left = 0;
   int gap_left = 0;
   int stall_mode = 0;
   int mode_left = 0;
   int mismatch_count = 0;
   int cycle_count = 0;

   rle_byte_encoder_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // Encoder model
   // ------------------------------------------------------------------------
   function void release_pending();
      if (run_extra != 0) begin
         code_bytes = {code_bytes, RUN_FLAG | 8'(run_extra + 1)};
         code_bytes = {code_bytes, held_bytes[0]};
      end else if (held_len != 0) begin
         code_bytes = {code_bytes, 8'(held_len)};
         for (int i = 0; i < held_len; i++) code_bytes = {code_bytes, held_bytes[i]};
      end
      held_len = 0;
      run_extra = 0;
   endfunction

   function void hold_byte(input logic [7:0] b);
      held_bytes[held_len] = b;
      held_len++;
   endfunction

   function void take_data_byte(input logic [7:0] b);
      if (held_len == 0) begin
         hold_byte(b);
      end else if (b == held_bytes[held_len - 1]) begin
         if (run_extra == 0 && held_len >= 2) begin
            held_len--;
            release_pending();
            hold_byte(b);
         end
         run_extra++;
         if (run_extra >= MAX_COUNT - 1) release_pending();
      end else begin
         if (run_extra != 0) release_pending();
         hold_byte(b);
         if (held_len >= MAX_COUNT) release_pending();
      end
   endfunction

   function void encode_input(input req_type w);
      rsp_type     r;
      int unsigned idx;
      int unsigned cnt;
      code_bytes.delete();
      if (w.command == CMD_DATA) begin
         take_data_byte(w.data_byte);
      end else begin
         release_pending();
         code_bytes = {code_bytes, END_CODE};
      end
      idx = 0;
      while (idx < code_bytes.size()) begin
         r = '0;
         cnt = 0;
         while (cnt < OUT_LANES && idx < code_bytes.size()) begin
            r.packed_bytes[8*cnt +: 8] = code_bytes[idx];
            cnt++;
            idx++;
         end
         r.byte_count = COUNT_W'(cnt);
         r.final_group = (idx >= code_bytes.size());
         coded_words = {coded_words, r};
      end
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus builders
   // ------------------------------------------------------------------------
   function void add_data(input logic [7:0] b);
      req_type w;
      w.command = CMD_DATA;
      w.data_byte = b;
      source_words = {source_words, w};
      last_pushed = b;
   endfunction

   function void add_end();
      req_type w;
      w.command = CMD_END;
      w.data_byte = 8'($urandom_range(0, 255));
      source_words = {source_words, w};
   endfunction

   function void add_run(input logic [7:0] b, input int len);
      repeat (len) add_data(b);
   endfunction

   function void add_literal(input int len);
      logic [7:0] b;
      b = last_pushed + 8'($urandom_range(1, 255));
      repeat (len) begin
         add_data(b);
         b = b + 8'($urandom_range(1, 255));
      end
   endfunction

   function void add_noise(input int len);
      logic [7:0] base;
      base = 8'($urandom_range(0, 255));
      repeat (len) add_data(base ^ 8'($urandom_range(0, 3)));
   endfunction

   function void build_random_planes();
      while (source_words.size() < TARGET_WORDS) begin
         repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: add_run(8'($urandom_range(0, 255)), $urandom_range(2, 9));
               4, 5, 6: add_literal($urandom_range(1, 12));
               7: add_noise($urandom_range(1, 10));
               8: begin
                  if ($urandom_range(0, 7) == 0)
                     add_run(8'($urandom_range(0, 255)), $urandom_range(100, 140));
                  else
                     add_run(8'($urandom_range(0, 255)), $urandom_range(1, 3));
               end
               default: begin
                  if ($urandom_range(0, 7) == 0) add_literal($urandom_range(100, 140));
                  else add_literal($urandom_range(1, 3));
               end
            endcase
         end
         if ($urandom_range(0, 5) != 0) add_end();
      end
      add_end();
   endfunction

   // ------------------------------------------------------------------------
   // Sender
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) encode_input(req_payload);
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (source_words.size() > 0) begin
               req_valid <= 1'b1;
               req_payload <= source_words.pop_front();
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 32);
                  gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver and checker
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (coded_words.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected word: bytes=%h count=%0d final=%b",
                           rsp_payload.packed_bytes, rsp_payload.byte_count,
                           rsp_payload.final_group);
            end else begin
               want = coded_words.pop_front();
               if (rsp_payload.packed_bytes !== want.packed_bytes ||
                   rsp_payload.byte_count !== want.byte_count ||
                   rsp_payload.final_group !== want.final_group) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch: expected bytes=%h count=%0d final=%b,",
                              want.packed_bytes, want.byte_count, want.final_group,
                              " got bytes=%h count=%0d final=%b",
                              rsp_payload.packed_bytes, rsp_payload.byte_count,
                              rsp_payload.final_group);
               end
            end
         end
         if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            mode_left <= $urandom_range(50, 300);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= ((cycle_count % 7) < 3);
         endcase
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("rle_byte_encoder_core verification failed");
         $finish;
      end
   end

   initial begin
      add_end();
      source_words = {source_words, req_type'{command: CMD_END, data_byte: 8'hFF}};
      add_data(8'h00); add_end();
      add_data(8'hFF); add_data(8'hFF); add_end();
      add_data(8'h01); add_data(8'h02); add_data(8'h03); add_data(8'h03);
      add_data(8'h03); add_data(8'h04); add_end();
      add_data(8'h55); add_data(8'hAA); add_data(8'h55); add_data(8'hAA); add_end();
      add_data(8'h7F); add_data(8'h80); add_data(8'h80); add_end();

      // hit both 127 caps at least once
      add_run(8'($urandom_range(0, 255)), $urandom_range(127, 130));
      add_end();
      add_literal($urandom_range(127, 130));
      add_end();
      build_random_planes();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      while (source_words.size() != 0 || req_valid) @(negedge clock);
      while (coded_words.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("rle_byte_encoder_core verification clean");
      end else begin
         $display("rle_byte_encoder_core verification failed");
      end
      $finish;
   end

endmodule
